>>> hdl/grc_pkg.sv
// Shared types and constants for the grid ray caster.
package grc_pkg;
	localparam int MAP_CELLS = 4096;
	localparam int MAP_AW = $clog2(MAP_CELLS);
	localparam int POS_FRAC = 8;
	localparam int DIR_FRAC = 14;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	typedef enum logic [CFG_IW-1:0] {
		REG_CELL_SIZE = 3'd0,
		REG_MAP_WIDTH = 3'd1,
		REG_WORLD_W = 3'd2,
		REG_WORLD_H = 3'd3,
		REG_MAX_DIST = 3'd4
	} grc_reg_t;

	typedef struct packed {
		logic [10:0] cell_size;
		logic [12:0] map_width_cells;
		logic [15:0] world_width;
		logic [15:0] world_height;
		logic [15:0] max_distance;
	} grc_cfg_t;

	// One queued word: either a tile write or a classified cast.
	typedef struct packed {
		logic cast;
		logic [11:0] idx;
		logic wall;
		logic [23:0] px;
		logic [23:0] py;
		logic negx;
		logic negy;
		logic [16:0] ax;
		logic [16:0] ay;
	} grc_item_t;
endpackage

>>> hdl/grc_front.sv
// Input side: classifies accepted words and queues them for the cast engine.
module grc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [11:0] tile_index,
	input logic [7:0] tile_value,
	input logic [23:0] pos_x,
	input logic [23:0] pos_y,
	input logic signed [15:0] dir_x,
	input logic signed [15:0] dir_y,
	input logic clearing,
	output logic q_valid,
	output grc_pkg::grc_item_t q_item,
	input logic q_pop
);
	import grc_pkg::*;

	grc_item_t ent_q [2];
	grc_item_t item;
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;

	always_comb begin
		item.cast = op;
		item.idx = tile_index;
		item.wall = (tile_value == 8'd1);
		item.px = pos_x;
		item.py = pos_y;
		item.negx = dir_x[15];
		item.negy = dir_y[15];
		item.ax = dir_x[15] ? (17'h10000 - {1'b0, dir_x}) : {1'b0, dir_x};
		item.ay = dir_y[15] ? (17'h10000 - {1'b0, dir_y}) : {1'b0, dir_y};
	end

	assign in_ready = (cnt_q != 2'd2) && !clearing;
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

>>> hdl/grc_back.sv
// Cast engine: wall map, step-length setup and the cell-stepping loop.
module grc_back (
	input logic clk,
	input logic arst_n,
	input grc_pkg::grc_cfg_t cfg,
	input logic q_valid,
	input grc_pkg::grc_item_t q_item,
	output logic q_pop,
	output logic clearing,
	output logic out_valid,
	input logic out_ready,
	output logic [23:0] distance,
	output logic wall_side,
	output logic wall_hit
);
	import grc_pkg::*;

	localparam logic [29:0] UNIT_MAX = 30'h3FFF_FFFF;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_SQ, S_SUM, S_UNIT, S_DIV, S_SQL, S_SQRT, S_UST,
		S_PDL, S_PDIV, S_PST, S_ML, S_MUL, S_MST, S_STEP, S_CHK, S_RD, S_EV, S_OUT
	} state_t;

	state_t state_q;
	logic wall_mem [MAP_CELLS];
	logic mem_rd_q;
	logic [MAP_AW-1:0] clr_q;

	logic [23:0] px_q, py_q;
	logic negx_q, negy_q;
	logic [16:0] ax_q, ay_q;
	logic [30:0] sqx_q, sqy_q;
	logic [31:0] sum_q;
	logic [29:0] ux_q, uy_q;
	logic axis_q;
	logic [59:0] dq_q;
	logic [30:0] rem_q, dvs_q;
	logic [5:0] cnt_q;
	logic [59:0] r_q, bit_q;
	logic [48:0] acc_q;
	logic [29:0] ma_q;
	logic [18:0] mb_q;
	logic [1:0] mi_q;
	logic [18:0] dlx_q, dly_q;
	logic signed [19:0] tx_q, ty_q;
	logic [35:0] rlx_q, rly_q, incx_q, incy_q, dist_q;
	logic side_q, hit_q;
	logic negt_q, inb_q;
	logic [29:0] wx_q, wy_q;
	logic [32:0] idx_q;
	logic out_valid_q, out_side_q, out_hit_q;
	logic [23:0] out_dist_q;

	logic [10:0] cs_eff;
	logic [31:0] div_t;
	logic div_ge;
	logic [60:0] sq_rb;
	logic sq_ge;
	logic [48:0] acc_n;
	logic [18:0] cell_fx, off;
	logic [35:0] limit;
	logic mem_we;
	logic [MAP_AW-1:0] mem_wa;
	logic mem_wd;

	always_comb begin
		cs_eff = (cfg.cell_size == 11'd0) ? 11'd1 : cfg.cell_size;
		div_t = {rem_q, dq_q[59]};
		div_ge = (div_t >= {1'b0, dvs_q});
		sq_rb = {1'b0, r_q} + {1'b0, bit_q};
		sq_ge = ({1'b0, dq_q} >= sq_rb);
		acc_n = {acc_q[47:0], 1'b0} + (mb_q[18] ? {19'd0, ma_q} : 49'd0);
		cell_fx = {cs_eff, 8'd0};
		off = {rem_q[10:0], (axis_q ? py_q[7:0] : px_q[7:0])};
		limit = {12'd0, cfg.max_distance, 8'd0};
		mem_we = (state_q == S_CLR) || (state_q == S_IDLE && q_valid && !q_item.cast);
		mem_wa = (state_q == S_CLR) ? clr_q : q_item.idx[MAP_AW-1:0];
		mem_wd = (state_q == S_CLR) ? 1'b0 : q_item.wall;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign clearing = (state_q == S_CLR);
	assign out_valid = out_valid_q;
	assign distance = out_dist_q;
	assign wall_side = out_side_q;
	assign wall_hit = out_hit_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wall_mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= wall_mem[idx_q[MAP_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAP_AW'(MAP_CELLS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid && q_item.cast) begin
						px_q <= q_item.px;
						py_q <= q_item.py;
						negx_q <= q_item.negx;
						negy_q <= q_item.negy;
						ax_q <= q_item.ax;
						ay_q <= q_item.ay;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sqx_q <= 31'(34'(ax_q) * 34'(ax_q));
					sqy_q <= 31'(34'(ay_q) * 34'(ay_q));
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
					axis_q <= 1'b0;
					state_q <= S_UNIT;
				end
				S_UNIT: begin
					if ((axis_q ? ay_q : ax_q) == 17'd0) begin
						if (axis_q) uy_q <= UNIT_MAX;
						else ux_q <= UNIT_MAX;
						axis_q <= ~axis_q;
						state_q <= axis_q ? S_PDL : S_UNIT;
					end else begin
						dq_q <= {sum_q, 28'd0};
						rem_q <= '0;
						dvs_q <= axis_q ? sqy_q : sqx_q;
						cnt_q <= 6'd60;
						state_q <= S_DIV;
					end
				end
				S_DIV, S_PDIV: begin
					rem_q <= div_ge ? 31'(div_t - {1'b0, dvs_q}) : div_t[30:0];
					dq_q <= {dq_q[58:0], div_ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= (state_q == S_DIV) ? S_SQL : S_PST;
				end
				S_SQL: begin
					r_q <= '0;
					bit_q <= 60'd1 << 58;
					cnt_q <= 6'd30;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sq_ge) begin
						dq_q <= 60'({1'b0, dq_q} - sq_rb);
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= S_UST;
				end
				S_UST: begin
					if (axis_q) uy_q <= (r_q[59:30] != '0) ? UNIT_MAX : r_q[29:0];
					else ux_q <= (r_q[59:30] != '0) ? UNIT_MAX : r_q[29:0];
					axis_q <= ~axis_q;
					state_q <= axis_q ? S_PDL : S_UNIT;
				end
				S_PDL: begin
					dq_q <= {(axis_q ? py_q[23:8] : px_q[23:8]), 44'd0};
					rem_q <= '0;
					dvs_q <= {20'd0, cs_eff};
					cnt_q <= 6'd16;
					state_q <= S_PDIV;
				end
				S_PST: begin
					// Start cell and the gap to the first boundary on this axis, the gap in Q.8.
					if (axis_q) begin
						ty_q <= {4'd0, dq_q[15:0]};
						dly_q <= negy_q ? off : cell_fx - off;
					end else begin
						tx_q <= {4'd0, dq_q[15:0]};
						dlx_q <= negx_q ? off : cell_fx - off;
					end
					axis_q <= ~axis_q;
					mi_q <= 2'd0;
					state_q <= axis_q ? S_ML : S_PDL;
				end
				S_ML: begin
					ma_q <= mi_q[0] ? uy_q : ux_q;
					case (mi_q)
						2'd0: mb_q <= dlx_q;
						2'd1: mb_q <= dly_q;
						default: mb_q <= {8'd0, cs_eff};
					endcase
					acc_q <= '0;
					cnt_q <= 6'd19;
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= acc_n;
					mb_q <= {mb_q[17:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= S_MST;
				end
				S_MST: begin
					case (mi_q)
						2'd0: rlx_q <= 36'(acc_q >> DIR_FRAC);
						2'd1: rly_q <= 36'(acc_q >> DIR_FRAC);
						2'd2: incx_q <= 36'(acc_q >> (DIR_FRAC - POS_FRAC));
						default: incy_q <= 36'(acc_q >> (DIR_FRAC - POS_FRAC));
					endcase
					mi_q <= mi_q + 2'd1;
					dist_q <= '0;
					side_q <= 1'b0;
					hit_q <= 1'b0;
					if (mi_q != 2'd3) state_q <= S_ML;
					else state_q <= (cfg.max_distance == 16'd0) ? S_OUT : S_STEP;
				end
				S_STEP: begin
					if (rlx_q < rly_q) begin
						tx_q <= negx_q ? tx_q - 20'sd1 : tx_q + 20'sd1;
						dist_q <= rlx_q;
						rlx_q <= rlx_q + incx_q;
						side_q <= 1'b0;
					end else begin
						ty_q <= negy_q ? ty_q - 20'sd1 : ty_q + 20'sd1;
						dist_q <= rly_q;
						rly_q <= rly_q + incy_q;
						side_q <= 1'b1;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					negt_q <= tx_q[19] | ty_q[19];
					wx_q <= 30'(30'(tx_q[18:0]) * 30'(cs_eff));
					wy_q <= 30'(30'(ty_q[18:0]) * 30'(cs_eff));
					idx_q <= 33'(ty_q[18:0]) * 33'(cfg.map_width_cells) + 33'(tx_q[18:0]);
					state_q <= S_RD;
				end
				S_RD: begin
					inb_q <= !negt_q && (wx_q < {14'd0, cfg.world_width})
						&& (wy_q < {14'd0, cfg.world_height})
						&& (idx_q < 33'(MAP_CELLS));
					state_q <= S_EV;
				end
				S_EV: begin
					hit_q <= inb_q & mem_rd_q;
					if ((inb_q & mem_rd_q) || dist_q >= limit) state_q <= S_OUT;
					else state_q <= S_STEP;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_dist_q <= (dist_q[35:24] != '0) ? 24'hFF_FFFF : dist_q[23:0];
						out_side_q <= side_q;
						out_hit_q <= hit_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/grid_ray_caster.sv
// Top level of the grid ray caster: configuration registers and block wiring.
// After reset the wall map is cleared, during which no word is accepted.
// A tile write then goes into the map straight from the idle state. A cast
// runs a setup (two 60-step divisions and two 30-step square roots for the
// step lengths, skipped for an axis whose direction component is zero, two
// 16-step divisions for the start cells and four 19-step serial multiplies)
// and then passes the step, check, read and evaluate states for every cell
// boundary crossed. A two-word queue lets the input keep accepting while a
// cast runs, and a result register holds the last result until it is taken.
module grid_ray_caster (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [grc_pkg::CFG_IW-1:0] cfg_index,
	input logic [grc_pkg::CFG_DW-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [11:0] tile_index,
	input logic [7:0] tile_value,
	input logic [23:0] pos_x,
	input logic [23:0] pos_y,
	input logic signed [15:0] dir_x,
	input logic signed [15:0] dir_y,
	output logic out_valid,
	input logic out_ready,
	output logic [23:0] distance,
	output logic wall_side,
	output logic wall_hit
);
	import grc_pkg::*;

	grc_cfg_t cfg_q;
	grc_item_t q_item;
	logic q_valid, q_pop, clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_size <= 11'd64;
			cfg_q.map_width_cells <= 13'd64;
			cfg_q.world_width <= 16'd4096;
			cfg_q.world_height <= 16'd4096;
			cfg_q.max_distance <= 16'd750;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CELL_SIZE: cfg_q.cell_size <= cfg_data[10:0];
				REG_MAP_WIDTH: cfg_q.map_width_cells <= cfg_data[12:0];
				REG_WORLD_W: cfg_q.world_width <= cfg_data;
				REG_WORLD_H: cfg_q.world_height <= cfg_data;
				REG_MAX_DIST: cfg_q.max_distance <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	grc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .tile_index(tile_index), .tile_value(tile_value),
		.pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y),
		.clearing(clearing),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	grc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.clearing(clearing),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance(distance), .wall_side(wall_side), .wall_hit(wall_hit)
	);
endmodule
